[hdl/urtb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_pkg
// Shared types for the uart receive/transmit ring buffer block.
// ----------------------------------------------------------------------------
package urtb_pkg;

    // event codes carried on the command field
    typedef enum logic [1:0] {
        CMD_RX_BYTE   = 2'd0,
        CMD_CPU_READ  = 2'd1,
        CMD_CPU_WRITE = 2'd2,
        CMD_TX_DONE   = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic take;   // input transaction accepted this cycle
        logic load;   // move pending result into the output register
    } t_ctl;

endpackage

[hdl/urtb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/urtb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ctrl
// Handshake controller: accepts one event, then loads its result once the
// output register is free.
// ----------------------------------------------------------------------------
module urtb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output urtb_pkg::t_ctl o_ctl
);
    import urtb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_ctl       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait for the ram read and a free output register
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/urtb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_dp
// Ring buffer datapath: receive and transmit stores, head and tail indices,
// busy flag, overflow counter and the result register.
// ----------------------------------------------------------------------------
module urtb_dp #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  urtb_pkg::t_ctl i_ctl,
    input  logic [1:0]     i_cmd,
    input  logic [7:0]     i_data,
    output logic [7:0]     o_read_data,
    output logic           o_read_empty,
    output logic           o_write_refused,
    output logic           o_send_valid,
    output logic [7:0]     o_send_data,
    output logic [3:0]     o_rx_count,
    output logic [3:0]     o_tx_count,
    output logic [3:0]     o_tx_free,
    output logic [7:0]     o_overflow_count,
    output logic           o_tx_busy
);
    import urtb_pkg::*;

    localparam int RIW = $clog2(RX_DEPTH);
    localparam int TIW = $clog2(TX_DEPTH);

    logic [RIW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [TIW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic           r_busy, n_busy;
    logic [7:0]     r_ovf, n_ovf;

    // pending result flags for the event in flight
    logic       r_p_empty, n_p_empty;
    logic       r_p_read_ok, n_p_read_ok;
    logic       r_p_refused, n_p_refused;
    logic       r_p_direct, n_p_direct;
    logic       r_p_queued, n_p_queued;
    logic [7:0] r_p_data;

    logic [RIW-1:0] rx_tail_nxt, rx_head_nxt;
    logic [TIW-1:0] tx_tail_nxt, tx_head_nxt;
    logic           rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [7:0]     rx_rd_data, tx_rd_data;
    t_cmd           cmd;

    logic [RIW:0]   rx_diff;
    logic [TIW:0]   tx_diff;
    logic [RIW-1:0] rx_used;
    logic [TIW-1:0] tx_used, tx_free;
    logic [RIW+3:0] rx_used_ext;
    logic [TIW+3:0] tx_used_ext, tx_free_ext;

    logic [7:0] r_o_read_data, r_o_send_data, r_o_ovf;
    logic       r_o_empty, r_o_refused, r_o_send_valid, r_o_busy;
    logic [3:0] r_o_rx_count, r_o_tx_count, r_o_tx_free;

    assign cmd = t_cmd'(i_cmd);

    assign rx_tail_nxt = (r_rx_tail == RIW'(RX_DEPTH - 1)) ? '0 : r_rx_tail + RIW'(1);
    assign rx_head_nxt = (r_rx_head == RIW'(RX_DEPTH - 1)) ? '0 : r_rx_head + RIW'(1);
    assign tx_tail_nxt = (r_tx_tail == TIW'(TX_DEPTH - 1)) ? '0 : r_tx_tail + TIW'(1);
    assign tx_head_nxt = (r_tx_head == TIW'(TX_DEPTH - 1)) ? '0 : r_tx_head + TIW'(1);

    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_busy      = r_busy;
        n_ovf       = r_ovf;
        n_p_empty   = 1'b0;
        n_p_read_ok = 1'b0;
        n_p_refused = 1'b0;
        n_p_direct  = 1'b0;
        n_p_queued  = 1'b0;
        rx_wr_en    = 1'b0;
        rx_rd_en    = 1'b0;
        tx_wr_en    = 1'b0;
        tx_rd_en    = 1'b0;
        if (i_ctl.take) begin
            unique case (cmd)
                CMD_RX_BYTE: begin
                    rx_wr_en  = 1'b1;
                    n_rx_tail = rx_tail_nxt;
                    // tail catching the head drops the queued bytes
                    if (rx_tail_nxt == r_rx_head) begin
                        n_ovf = r_ovf + 8'd1;
                    end
                end
                CMD_CPU_READ: begin
                    if (r_rx_tail == r_rx_head) begin
                        n_p_empty = 1'b1;
                    end else begin
                        rx_rd_en    = 1'b1;
                        n_p_read_ok = 1'b1;
                        n_rx_head   = rx_head_nxt;
                    end
                end
                CMD_CPU_WRITE: begin
                    if (tx_tail_nxt == r_tx_head) begin
                        n_p_refused = 1'b1;
                    end else if (!r_busy) begin
                        n_p_direct = 1'b1;
                        n_busy     = 1'b1;
                    end else begin
                        tx_wr_en  = 1'b1;
                        n_tx_tail = tx_tail_nxt;
                    end
                end
                CMD_TX_DONE: begin
                    if (r_tx_tail != r_tx_head) begin
                        tx_rd_en   = 1'b1;
                        n_p_queued = 1'b1;
                        n_tx_head  = tx_head_nxt;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = r_busy;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_busy    <= 1'b0;
            r_ovf     <= '0;
        end else begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_busy    <= n_busy;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_p_empty   <= n_p_empty;
            r_p_read_ok <= n_p_read_ok;
            r_p_refused <= n_p_refused;
            r_p_direct  <= n_p_direct;
            r_p_queued  <= n_p_queued;
            r_p_data    <= i_data;
        end
    end

    urtb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rx_wr_en),
        .i_wr_addr (r_rx_tail),
        .i_wr_data (i_data),
        .i_rd_en   (rx_rd_en),
        .i_rd_addr (r_rx_head),
        .o_rd_data (rx_rd_data)
    );

    urtb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tx_wr_en),
        .i_wr_addr (r_tx_tail),
        .i_wr_data (i_data),
        .i_rd_en   (tx_rd_en),
        .i_rd_addr (r_tx_head),
        .o_rd_data (tx_rd_data)
    );

    // occupancy modulo depth, from the indices after the event
    always_comb begin
        rx_diff = {1'b0, r_rx_tail} - {1'b0, r_rx_head};
        if (r_rx_tail < r_rx_head) begin
            rx_diff = rx_diff + (RIW + 1)'(RX_DEPTH);
        end
        tx_diff = {1'b0, r_tx_tail} - {1'b0, r_tx_head};
        if (r_tx_tail < r_tx_head) begin
            tx_diff = tx_diff + (TIW + 1)'(TX_DEPTH);
        end
    end

    assign rx_used     = rx_diff[RIW-1:0];
    assign tx_used     = tx_diff[TIW-1:0];
    assign tx_free     = TIW'(TX_DEPTH - 1) - tx_used;
    assign rx_used_ext = {4'd0, rx_used};
    assign tx_used_ext = {4'd0, tx_used};
    assign tx_free_ext = {4'd0, tx_free};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_o_read_data  <= r_p_read_ok ? rx_rd_data : 8'd0;
            r_o_empty      <= r_p_empty;
            r_o_refused    <= r_p_refused;
            r_o_send_valid <= r_p_direct || r_p_queued;
            r_o_send_data  <= r_p_direct ? r_p_data : (r_p_queued ? tx_rd_data : 8'd0);
            r_o_rx_count   <= rx_used_ext[3:0];
            r_o_tx_count   <= tx_used_ext[3:0];
            r_o_tx_free    <= tx_free_ext[3:0];
            r_o_ovf        <= r_ovf;
            r_o_busy       <= r_busy;
        end
    end

    assign o_read_data      = r_o_read_data;
    assign o_read_empty     = r_o_empty;
    assign o_write_refused  = r_o_refused;
    assign o_send_valid     = r_o_send_valid;
    assign o_send_data      = r_o_send_data;
    assign o_rx_count       = r_o_rx_count;
    assign o_tx_count       = r_o_tx_count;
    assign o_tx_free        = r_o_tx_free;
    assign o_overflow_count = r_o_ovf;
    assign o_tx_busy        = r_o_busy;

endmodule

[hdl/uart_rx_tx_ring_buffers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte rings between a cpu and a serial line.
// ----------------------------------------------------------------------------
// Each input transaction is one event (line byte received, cpu read, cpu
// write, transmit done) and yields exactly one result transaction carrying
// the read byte or empty flag, the write refusal, any byte handed to the
// transmitter, both ring occupancies, the free transmit places, the wrapping
// receive overflow count and the transmitter busy flag. On acceptance an
// event updates the indices and issues the registered ram read; the load
// state then loads the result register once the output register is free.
// A new event is taken while the previous result still waits, but not
// before the previous event has loaded its result. Each ring holds at
// most depth minus one bytes; a received byte that fills the receive
// ring counts an overflow and leaves it reading as empty.
module uart_rx_tx_ring_buffers #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_read_empty,
    output logic       o_write_refused,
    output logic       o_send_valid,
    output logic [7:0] o_send_data,
    output logic [3:0] o_rx_count,
    output logic [3:0] o_tx_count,
    output logic [3:0] o_tx_free,
    output logic [7:0] o_overflow_count,
    output logic       o_tx_busy
);
    import urtb_pkg::*;

    t_ctl ctl;

    urtb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    urtb_dp #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_cmd            (i_cmd),
        .i_data           (i_data),
        .o_read_data      (o_read_data),
        .o_read_empty     (o_read_empty),
        .o_write_refused  (o_write_refused),
        .o_send_valid     (o_send_valid),
        .o_send_data      (o_send_data),
        .o_rx_count       (o_rx_count),
        .o_tx_count       (o_tx_count),
        .o_tx_free        (o_tx_free),
        .o_overflow_count (o_overflow_count),
        .o_tx_busy        (o_tx_busy)
    );

endmodule
